// ----- rtl/mdc_pkg.sv -----
// Shared types, codes and the memory type classifier for the descriptor coalescer.
// No dependencies; used by every module of the block.
package mdc_pkg;

   // Firmware memory type codes, standard numbering
   localparam logic [31:0] TYPE_RESERVED     = 32'd0;
   localparam logic [31:0] TYPE_LOADER_CODE  = 32'd1;
   localparam logic [31:0] TYPE_LOADER_DATA  = 32'd2;
   localparam logic [31:0] TYPE_BS_CODE      = 32'd3;
   localparam logic [31:0] TYPE_BS_DATA      = 32'd4;
   localparam logic [31:0] TYPE_RT_CODE      = 32'd5;
   localparam logic [31:0] TYPE_RT_DATA      = 32'd6;
   localparam logic [31:0] TYPE_CONVENTIONAL = 32'd7;
   localparam logic [31:0] TYPE_UNUSABLE     = 32'd8;
   localparam logic [31:0] TYPE_ACPI_RECLAIM = 32'd9;
   localparam logic [31:0] TYPE_ACPI_NVS     = 32'd10;
   localparam logic [31:0] TYPE_MMIO         = 32'd11;
   localparam logic [31:0] TYPE_MMIO_PORT    = 32'd12;
   localparam logic [31:0] TYPE_PAL_CODE     = 32'd13;

   // Region classes
   localparam logic [1:0] CLASS_FREE    = 2'd0;
   localparam logic [1:0] CLASS_RUNTIME = 2'd1;
   localparam logic [1:0] CLASS_ACPI    = 2'd2;
   localparam logic [1:0] CLASS_MMIO    = 2'd3;

   // Request modes
   localparam logic MODE_DESC  = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   // Response kinds
   localparam logic KIND_REGION   = 1'b0;
   localparam logic KIND_BAD_TYPE = 1'b1;

   typedef struct packed {
      logic        mode;
      logic [31:0] efi_type;
      logic [63:0] phys_start;
      logic [63:0] desc_pages;
      logic [31:0] attr_low;
   } req_payload_type;

   typedef struct packed {
      logic       drop;
      logic       bad;
      logic [1:0] cls;
   } class_info_type;

   // Map a memory type to its region class, or flag it dropped / unknown
   function automatic class_info_type classify(input logic [31:0] efi_type);
      class_info_type info;
      info = '{drop: 1'b0, bad: 1'b0, cls: CLASS_FREE};
      case (efi_type)
         TYPE_RESERVED, TYPE_UNUSABLE, TYPE_ACPI_NVS, TYPE_PAL_CODE: begin
            info.drop = 1'b1;
         end
         TYPE_LOADER_CODE, TYPE_LOADER_DATA, TYPE_BS_CODE, TYPE_BS_DATA,
         TYPE_CONVENTIONAL: begin
            info.cls = CLASS_FREE;
         end
         TYPE_RT_CODE, TYPE_RT_DATA: begin
            info.cls = CLASS_RUNTIME;
         end
         TYPE_ACPI_RECLAIM: begin
            info.cls = CLASS_ACPI;
         end
         TYPE_MMIO, TYPE_MMIO_PORT: begin
            info.cls = CLASS_MMIO;
         end
         default: begin
            info.bad = 1'b1;
         end
      endcase
      return info;
   endfunction

endpackage

// ----- rtl/mdc_ifs.sv -----
// Valid/ready channel interfaces for descriptor requests and region responses.
// No dependencies.
interface mdc_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [31:0] efi_type;
   logic [63:0] phys_start;
   logic [63:0] desc_pages;
   logic [31:0] attr_low;

   modport source (output valid, mode, efi_type, phys_start, desc_pages, attr_low,
                   input ready);
   modport sink   (input valid, mode, efi_type, phys_start, desc_pages, attr_low,
                   output ready);
endinterface

interface mdc_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic        final_res;
   logic [63:0] region_start;
   logic [63:0] region_pages;
   logic [1:0]  region_class;
   logic [31:0] region_attr;

   modport source (output valid, kind, final_res, region_start, region_pages,
                   region_class, region_attr, input ready);
   modport sink   (input valid, kind, final_res, region_start, region_pages,
                   region_class, region_attr, output ready);
endinterface

// ----- rtl/mdc_in_stage.sv -----
// Input register for descriptor requests.
// Depends on mdc_pkg and mdc_req_if.
module mdc_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   mdc_req_if.sink                  req_chan,
   output logic                     stage_valid,
   output mdc_pkg::req_payload_type stage_data,
   input  logic                     stage_take
);
   import mdc_pkg::*;

   logic            valid_ff;
   logic            valid_in;
   req_payload_type data_ff;
   logic            load;

   // Register is free when empty or when its request moves on this cycle
   assign req_chan.ready = !valid_ff || stage_take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (stage_take) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= '{mode:       req_chan.mode,
                      efi_type:   req_chan.efi_type,
                      phys_start: req_chan.phys_start,
                      desc_pages: req_chan.desc_pages,
                      attr_low:   req_chan.attr_low};
      end
   end

   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

endmodule

// ----- rtl/mdc_merge.sv -----
// Pending region state, merge decision and response register.
// Depends on mdc_pkg and mdc_rsp_if.
module mdc_merge #(
   parameter int PAGE_SHIFT = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     stage_valid,
   input  mdc_pkg::req_payload_type stage_data,
   output logic                     stage_take,
   mdc_rsp_if.source                rsp_chan
);
   import mdc_pkg::*;

   // Pending region
   logic        pend_valid_ff, pend_valid_in;
   logic [63:0] pend_start_ff, pend_start_in;
   logic [63:0] pend_pages_ff, pend_pages_in;
   logic [1:0]  pend_class_ff, pend_class_in;
   logic [31:0] pend_attr_ff,  pend_attr_in;

   // Response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_kind_ff,  rsp_kind_in;
   logic        rsp_final_ff, rsp_final_in;
   logic [63:0] rsp_start_ff, rsp_start_in;
   logic [63:0] rsp_pages_ff, rsp_pages_in;
   logic [1:0]  rsp_class_ff, rsp_class_in;
   logic [31:0] rsp_attr_ff,  rsp_attr_in;

   class_info_type info;
   logic [63:0]    pend_bytes;
   logic [63:0]    pend_end;
   logic           adjacent;
   logic           emit;
   logic           out_free;

   assign info       = classify(stage_data.efi_type);
   assign pend_bytes = pend_pages_ff << PAGE_SHIFT;
   assign pend_end   = pend_start_ff + pend_bytes;
   assign adjacent   = pend_valid_ff && (pend_class_ff == info.cls)
                       && (pend_end == stage_data.phys_start)
                       && (pend_attr_ff == stage_data.attr_low);

   // Does the request in the stage produce a response?
   always_comb begin
      if (stage_data.mode == MODE_FLUSH) begin
         emit = pend_valid_ff;
      end else if (info.drop) begin
         emit = 1'b0;
      end else if (info.bad) begin
         emit = 1'b1;
      end else begin
         emit = pend_valid_ff && !adjacent;
      end
   end

   // Requests without a response proceed even while the output is stalled
   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign stage_take = stage_valid && (out_free || !emit);

   // Next pending state and response
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_start_in = pend_start_ff;
      pend_pages_in = pend_pages_ff;
      pend_class_in = pend_class_ff;
      pend_attr_in  = pend_attr_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_final_in = rsp_final_ff;
      rsp_start_in = rsp_start_ff;
      rsp_pages_in = rsp_pages_ff;
      rsp_class_in = rsp_class_ff;
      rsp_attr_in  = rsp_attr_ff;

      if (stage_take) begin
         if (emit) begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_REGION;
            rsp_final_in = (stage_data.mode == MODE_FLUSH);
            rsp_start_in = pend_start_ff;
            rsp_pages_in = pend_pages_ff;
            rsp_class_in = pend_class_ff;
            rsp_attr_in  = pend_attr_ff;
         end

         if (stage_data.mode == MODE_FLUSH) begin
            pend_valid_in = 1'b0;
         end else if (info.bad) begin
            // unknown type: error response, state untouched
            rsp_kind_in  = KIND_BAD_TYPE;
            rsp_final_in = 1'b0;
            rsp_start_in = '0;
            rsp_pages_in = '0;
            rsp_class_in = CLASS_FREE;
            rsp_attr_in  = '0;
         end else if (!info.drop) begin
            if (adjacent) begin
               pend_pages_in = pend_pages_ff + stage_data.desc_pages;
            end else begin
               pend_valid_in = 1'b1;
               pend_start_in = stage_data.phys_start;
               pend_pages_in = stage_data.desc_pages;
               pend_class_in = info.cls;
               pend_attr_in  = stage_data.attr_low;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_start_ff <= pend_start_in;
      pend_pages_ff <= pend_pages_in;
      pend_class_ff <= pend_class_in;
      pend_attr_ff  <= pend_attr_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_final_ff  <= rsp_final_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_pages_ff  <= rsp_pages_in;
      rsp_class_ff  <= rsp_class_in;
      rsp_attr_ff   <= rsp_attr_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_kind_ff;
   assign rsp_chan.final_res    = rsp_final_ff;
   assign rsp_chan.region_start = rsp_start_ff;
   assign rsp_chan.region_pages = rsp_pages_ff;
   assign rsp_chan.region_class = rsp_class_ff;
   assign rsp_chan.region_attr  = rsp_attr_ff;

endmodule

// ----- rtl/memory_descriptor_coalescer_unit.sv -----
// Memory descriptor coalescer: merges adjacent firmware descriptors into regions.
// Path: an accepted request passes through the input register, then the response
//   register; requests with no response leave even while the output is stalled.
// Throughput: one request per cycle unless a response waits on a stalled output.
// Reset: synchronous; empties both registers and clears the pending region.
// Depends on mdc_pkg, mdc_ifs, mdc_in_stage and mdc_merge.
module memory_descriptor_coalescer_unit #(
   parameter int PAGE_SHIFT = 12
) (
   input  logic      clock,
   input  logic      reset,
   mdc_req_if.sink   req_chan,
   mdc_rsp_if.source rsp_chan
);
   import mdc_pkg::*;

   logic            stage_valid;
   logic            stage_take;
   req_payload_type stage_data;

   mdc_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .stage_take  (stage_take)
   );

   mdc_merge #(
      .PAGE_SHIFT (PAGE_SHIFT)
   ) u_merge (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .stage_data  (stage_data),
      .stage_take  (stage_take),
      .rsp_chan    (rsp_chan)
   );

   // Merge stage never consumes an empty input register
   assert property (@(posedge clock) disable iff (reset)
      stage_take |-> stage_valid)
      else $error("merge stage took a request from an empty register");

   // A request held in the input register keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      stage_valid && !stage_take |=> stage_valid && $stable(stage_data))
      else $error("held request lost or changed");

   // Error responses carry all-zero region fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.kind == KIND_BAD_TYPE |->
         !rsp_chan.final_res && rsp_chan.region_start == '0
         && rsp_chan.region_pages == '0 && rsp_chan.region_attr == '0
         && rsp_chan.region_class == CLASS_FREE)
      else $error("error response carries region data");

   // A flush only ever emits a region entry
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.final_res |-> rsp_chan.kind == KIND_REGION)
      else $error("final response is not a region entry");

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for memory_descriptor_coalescer_unit: directed and random descriptor
// streams with random valid/ready idling, checked against an in-bench coalescing model.
// Depends on mdc_pkg, mdc_ifs and the coalescer RTL.
module tb_top;
   import mdc_pkg::*;

   localparam int PAGE_SHIFT      = 12;
   localparam int RANDOM_ITEMS    = 950;
   localparam int STALL_LIMIT     = 2000;
   localparam int HOLD_OFF_AT     = 150;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 10;
   localparam int MAX_REPORTS     = 10;

   typedef struct {
      req_payload_type desc;
      int              gap;
   } req_entry_type;

   typedef struct packed {
      logic        kind;
      logic        final_res;
      logic [63:0] start;
      logic [63:0] pages;
      logic [1:0]  cls;
      logic [31:0] attr;
   } region_type;

   logic clock = 1'b0;
   logic reset;

   mdc_req_if req_chan ();
   mdc_rsp_if rsp_chan ();

   memory_descriptor_coalescer_unit #(
      .PAGE_SHIFT(PAGE_SHIFT)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   req_entry_type   pending_reqs[$];
   region_type      region_expect_q[$];
   req_payload_type in_flight;
   int              error_count   = 0;
   int              total_items   = 0;

   // Open region tracked by the bench model
   logic        open_valid = 1'b0;
   logic [63:0] open_start = '0;
   logic [63:0] open_pages = '0;
   logic [1:0]  open_class = CLASS_FREE;
   logic [31:0] open_attr  = '0;

   // Model of one request; returns 1 when the request yields a response
   function automatic bit coalesce(input req_payload_type d, output region_type r);
      logic [1:0]  cls;
      bit          drop;
      bit          bad;
      logic [63:0] open_end;
      r = '0;
      r.kind = KIND_REGION;
      if (d.mode == MODE_FLUSH) begin
         if (!open_valid) return 1'b0;
         r.final_res = 1'b1;
         r.start     = open_start;
         r.pages     = open_pages;
         r.cls       = open_class;
         r.attr      = open_attr;
         open_valid  = 1'b0;
         open_start  = '0;
         open_pages  = '0;
         open_class  = CLASS_FREE;
         open_attr   = '0;
         return 1'b1;
      end
      drop = 1'b0;
      bad  = 1'b0;
      cls  = CLASS_FREE;
      case (d.efi_type)
         TYPE_RESERVED, TYPE_UNUSABLE, TYPE_ACPI_NVS, TYPE_PAL_CODE: drop = 1'b1;
         TYPE_LOADER_CODE, TYPE_LOADER_DATA, TYPE_BS_CODE, TYPE_BS_DATA,
         TYPE_CONVENTIONAL: cls = CLASS_FREE;
         TYPE_RT_CODE, TYPE_RT_DATA: cls = CLASS_RUNTIME;
         TYPE_ACPI_RECLAIM: cls = CLASS_ACPI;
         TYPE_MMIO, TYPE_MMIO_PORT: cls = CLASS_MMIO;
         default: bad = 1'b1;
      endcase
      if (drop) return 1'b0;
      if (bad) begin
         r.kind = KIND_BAD_TYPE;
         return 1'b1;
      end
      if (open_valid) begin
         open_end = open_start + (open_pages << PAGE_SHIFT);
         if (open_class == cls && open_end == d.phys_start && open_attr == d.attr_low) begin
            open_pages = open_pages + d.desc_pages;
            return 1'b0;
         end
         r.start = open_start;
         r.pages = open_pages;
         r.cls   = open_class;
         r.attr  = open_attr;
      end
      open_start = d.phys_start;
      open_pages = d.desc_pages;
      open_class = cls;
      open_attr  = d.attr_low;
      if (open_valid) return 1'b1;
      open_valid = 1'b1;
      return 1'b0;
   endfunction

   // Queue one request; gaps vanish in every fourth stretch of 80 requests
   task automatic add_item(input logic mode, input logic [31:0] t, input logic [63:0] s,
                           input logic [63:0] p, input logic [31:0] a);
      req_entry_type e;
      e.desc.mode       = mode;
      e.desc.efi_type   = t;
      e.desc.phys_start = s;
      e.desc.desc_pages = p;
      e.desc.attr_low   = a;
      e.gap = ((total_items / 80) % 4 == 3) ? 0 : $urandom_range(0, 5);
      pending_reqs.push_back(e);
      total_items++;
   endtask

   function automatic logic [31:0] pick_type(input logic [1:0] cls);
      logic [31:0] free_types[5];
      free_types = '{TYPE_LOADER_CODE, TYPE_LOADER_DATA, TYPE_BS_CODE, TYPE_BS_DATA,
                     TYPE_CONVENTIONAL};
      case (cls)
         CLASS_FREE:    return free_types[$urandom_range(0, 4)];
         CLASS_RUNTIME: return $urandom_range(0, 1) ? TYPE_RT_CODE : TYPE_RT_DATA;
         CLASS_ACPI:    return TYPE_ACPI_RECLAIM;
         default:       return $urandom_range(0, 1) ? TYPE_MMIO : TYPE_MMIO_PORT;
      endcase
   endfunction

   function automatic logic [31:0] drop_type();
      case ($urandom_range(0, 3))
         0:       return TYPE_RESERVED;
         1:       return TYPE_UNUSABLE;
         2:       return TYPE_ACPI_NVS;
         default: return TYPE_PAL_CODE;
      endcase
   endfunction

   function automatic logic [63:0] rand_addr();
      case ($urandom_range(0, 9))
         0:       return 64'h0;
         1:       return {32'hFFFF_FFFF, $urandom} & ~64'hFFF;
         2:       return {$urandom, $urandom} & ~64'hFFF;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Mostly small page counts, some full-width ones
   function automatic logic [63:0] rand_pages();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 64'($urandom_range(0, 64));
      if (r < 95) return {$urandom, $urandom};
      return (r < 98) ? 64'hFFFF_FFFF_FFFF_FFFF : 64'h0;
   endfunction

   function automatic logic [31:0] rand_attr();
      return ($urandom_range(0, 99) < 70) ? 32'($urandom_range(0, 3)) : $urandom;
   endfunction

   // Request driver
   bit gap_loaded = 1'b0;
   int src_wait   = 0;

   always @(posedge clock) begin
      req_entry_type nxt;
      region_type    r;
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_loaded = 1'b0;
         src_wait   = 0;
      end else if (!(req_chan.valid && !req_chan.ready)) begin
         if (req_chan.valid) begin
            if (coalesce(in_flight, r)) region_expect_q.push_back(r);
         end
         if (!gap_loaded && pending_reqs.size() != 0) begin
            src_wait   = pending_reqs[0].gap;
            gap_loaded = 1'b1;
         end
         if (gap_loaded && src_wait == 0) begin
            nxt = pending_reqs.pop_front();
            gap_loaded = 1'b0;
            in_flight  = nxt.desc;
            req_chan.mode       <= nxt.desc.mode;
            req_chan.efi_type   <= nxt.desc.efi_type;
            req_chan.phys_start <= nxt.desc.phys_start;
            req_chan.desc_pages <= nxt.desc.desc_pages;
            req_chan.attr_low   <= nxt.desc.attr_low;
            req_chan.valid      <= 1'b1;
         end else begin
            if (gap_loaded) src_wait--;
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response monitor and sink-side stalls, with one long hold-off
   int sink_wait    = 0;
   int results_seen = 0;

   always @(posedge clock) begin
      region_type got;
      region_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         sink_wait = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.kind      = rsp_chan.kind;
            got.final_res = rsp_chan.final_res;
            got.start     = rsp_chan.region_start;
            got.pages     = rsp_chan.region_pages;
            got.cls       = rsp_chan.region_class;
            got.attr      = rsp_chan.region_attr;
            if (region_expect_q.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: unexpected response kind=%0b final=%0b start=%h",
                           $realtime, got.kind, got.final_res, got.start);
                  $display("   pages=%h cls=%0d attr=%h", got.pages, got.cls, got.attr);
               end
            end else begin
               want = region_expect_q.pop_front();
               if (got.kind !== want.kind || got.final_res !== want.final_res ||
                   got.start !== want.start || got.pages !== want.pages ||
                   got.cls !== want.cls || got.attr !== want.attr) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("   exp kind=%0b final=%0b start=%h pages=%h cls=%0d attr=%h",
                              want.kind, want.final_res, want.start, want.pages, want.cls,
                              want.attr);
                     $display("   got kind=%0b final=%0b start=%h pages=%h cls=%0d attr=%h",
                              got.kind, got.final_res, got.start, got.pages, got.cls,
                              got.attr);
                  end
               end
            end
            results_seen++;
            if (results_seen == HOLD_OFF_AT)
               sink_wait = HOLD_OFF_CYCLES;
            else if ((results_seen / 64) % 3 == 1)
               sink_wait = 0;
            else
               sink_wait = $urandom_range(0, 5);
         end else if (sink_wait > 0) begin
            sink_wait--;
         end
         rsp_chan.ready <= (sink_wait == 0);
      end
   end

   // Watchdog on cycles without any handshake
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int          sel;
      int          run_len;
      int          brk;
      logic [1:0]  run_cls;
      logic [1:0]  cls_k;
      logic [31:0] run_attr;
      logic [31:0] attr_k;
      logic [63:0] run_start;
      logic [63:0] pages;

      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.mode       = MODE_DESC;
      req_chan.efi_type   = '0;
      req_chan.phys_start = '0;
      req_chan.desc_pages = '0;
      req_chan.attr_low   = '0;
      rsp_chan.ready      = 1'b0;

      // Directed: flush with nothing open, merges, breaks on attr and class
      add_item(MODE_FLUSH, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      add_item(MODE_DESC, TYPE_CONVENTIONAL, 64'h0, 64'h1, 32'hF);
      add_item(MODE_DESC, TYPE_LOADER_CODE, 64'h1000, 64'h2, 32'hF);
      add_item(MODE_DESC, TYPE_BS_DATA, 64'h3000, 64'h1, 32'hE);
      add_item(MODE_DESC, TYPE_RT_CODE, 64'h4000, 64'h3, 32'hE);
      add_item(MODE_DESC, TYPE_ACPI_RECLAIM, 64'h7000, 64'h1, 32'hE);
      // Top of the address space: adjacency and page sum both wrap
      add_item(MODE_DESC, TYPE_MMIO, 64'hFFFF_FFFF_FFFF_F000, 64'h1, 32'hFFFF_FFFF);
      add_item(MODE_DESC, TYPE_MMIO_PORT, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      add_item(MODE_DESC, TYPE_MMIO, 64'hFFFF_FFFF_FFFF_F000, 64'h5, 32'hFFFF_FFFF);
      // Dropped types leave the open region alone
      add_item(MODE_DESC, TYPE_RESERVED, 64'h0, 64'h0, 32'h0);
      add_item(MODE_DESC, TYPE_UNUSABLE, 64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 32'hFFFF_FFFF);
      add_item(MODE_DESC, TYPE_ACPI_NVS, 64'h4000, 64'h7, 32'h1);
      add_item(MODE_DESC, TYPE_PAL_CODE, 64'h1234_5000, 64'h9, 32'h2);
      // Unknown types give an error response only
      add_item(MODE_DESC, 32'd14, 64'h0, 64'h1, 32'h0);
      add_item(MODE_DESC, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
               32'hFFFF_FFFF);
      add_item(MODE_FLUSH, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      add_item(MODE_FLUSH, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);
      // Zero-page descriptor merges with one at the same start
      add_item(MODE_DESC, TYPE_LOADER_DATA, 64'h8000, 64'h0, 32'h3);
      add_item(MODE_DESC, TYPE_BS_CODE, 64'h8000, 64'h4, 32'h3);
      add_item(MODE_DESC, TYPE_RT_DATA, 64'hC000, 64'h2, 32'h3);
      add_item(MODE_DESC, TYPE_RT_CODE, 64'hE000, 64'h2, 32'h3);
      add_item(MODE_FLUSH, $urandom, {$urandom, $urandom}, {$urandom, $urandom}, $urandom);

      // Random: mostly contiguous runs, with noise and broken runs
      while (total_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 60) begin
            run_len   = $urandom_range(1, 8);
            run_cls   = 2'($urandom_range(0, 3));
            run_attr  = rand_attr();
            run_start = rand_addr();
            for (int k = 0; k < run_len; k++) begin
               pages  = rand_pages();
               brk    = $urandom_range(0, 99);
               cls_k  = run_cls;
               attr_k = run_attr;
               if (brk < 5)
                  add_item(MODE_DESC, drop_type(), rand_addr(), rand_pages(), rand_attr());
               else if (brk >= 95)
                  cls_k = run_cls + 2'd1;
               else if (brk >= 90)
                  attr_k = run_attr ^ (32'h1 << $urandom_range(0, 31));
               add_item(MODE_DESC, pick_type(cls_k), run_start, pages, attr_k);
               run_start = run_start + (pages << PAGE_SHIFT);
            end
            if ($urandom_range(0, 1))
               add_item(MODE_FLUSH, $urandom, rand_addr(), rand_pages(), $urandom);
         end else if (sel < 72) begin
            add_item(MODE_FLUSH, $urandom, rand_addr(), rand_pages(), $urandom);
         end else if (sel < 82) begin
            add_item(MODE_DESC, drop_type(), rand_addr(), rand_pages(), rand_attr());
         end else if (sel < 90) begin
            add_item(MODE_DESC,
                     ($urandom_range(0, 3) == 0) ? 32'($urandom_range(14, 15))
                                                 : $urandom_range(14, 32'hFFFF_FFFF),
                     rand_addr(), rand_pages(), rand_attr());
         end else begin
            add_item(MODE_DESC, 32'($urandom_range(0, 15)), rand_addr(), rand_pages(),
                     rand_attr());
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_chan.valid || region_expect_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && region_expect_q.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
